[design/asps_pkg.sv]
// Shared constants, codes and types for the armed periodic send scheduler.
// No dependencies; imported by armed_periodic_send_scheduler.
package asps_pkg;

  // Slot table geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned VAL_W  = 32;

  // Input item codes
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ARM    = 3'd1;
  localparam logic [2:0] FUNC_DISARM = 3'd2;
  localparam logic [2:0] FUNC_START  = 3'd3;
  localparam logic [2:0] FUNC_STOP   = 3'd4;

  // Result event codes
  localparam logic [1:0] EV_FIRE    = 2'd0;
  localparam logic [1:0] EV_REFUSED = 2'd1;
  localparam logic [1:0] EV_EXPIRED = 2'd2;

  // Arm window after reset, in ms
  localparam logic [TIME_W-1:0] ARM_WINDOW_RST = TIME_W'(60000);

  typedef struct packed {
    logic [1:0]       ev;
    logic [3:0]       slot;
    logic [VAL_W-1:0] value;
  } res_t;

  // Wrap-safe signed difference is strictly positive
  function automatic logic diff_pos(logic [TIME_W-1:0] d);
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

[design/armed_periodic_send_scheduler.sv]
// Armed periodic send scheduler: transmit gate with arm timeout plus a table
// of cyclic send slots walked by a small sequencer. Depends on asps_pkg.
//
// Usage:
// - s_axis carries one request item per handshake: 1 ms tick, arm, disarm,
//   start slot or stop slot. Config write channel (cfg_valid_i/cfg_data_i)
//   sets the arm window in ms; cfg_ready_o is always high.
// - m_axis carries result items: slot fire, start refused, or gate expired.
//   tlast marks the final result caused by one request.
// - Arm, disarm, stop and accepted starts complete in S_IDLE. A refused start
//   also passes through S_FLUSH and waits there on m_axis.
// - A tick passes S_GATE, then walks every slot: S_SCAN only when disabled,
//   S_SCAN and S_DUE when enabled but not due, and S_SCAN, S_DUE and S_FIRE
//   when it fires, then ends in S_FLUSH. A tick that closes the gate skips
//   the walk. The walk is set by the slot table read once per slot at the
//   walk index and the deadline step and resync test done in separate
//   states per firing slot.
// - s_axis_tready_o is high only while the sequencer is idle.
// - Results pass through a one-item hold stage (to find tlast) and an
//   output register; a stalled receiver stalls the slot walk in place.
// - Reset closes the gate, disables all slots, clears time to zero and
//   loads the arm window with 60000 ms. Slot table contents are not reset.
module armed_periodic_send_scheduler
  import asps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Config: arm window in ms
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // Requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] func, [6:3] slot, [22:7] period_ms, [54:23] send_value, [55] zero
  input  logic [55:0] s_axis_tdata_i,
  // Results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] event_res, [5:2] slot_res, [37:6] send_value_res, [39:38] zero
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATE,
    S_SCAN,
    S_DUE,
    S_FIRE,
    S_FLUSH
  } state_e;

  // Request fields
  logic [2:0]       in_func;
  logic [3:0]       in_slot;
  logic [PER_W-1:0] in_period;
  logic [VAL_W-1:0] in_value;

  assign in_func   = s_axis_tdata_i[2:0];
  assign in_slot   = s_axis_tdata_i[6:3];
  assign in_period = s_axis_tdata_i[22:7];
  assign in_value  = s_axis_tdata_i[54:23];

  // Control and data registers
  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic                gate_open_q, gate_open_d;
  logic [TIME_W-1:0]   gate_dl_q, gate_dl_d;
  logic [SLOTS-1:0]    en_q, en_d;
  logic [TIME_W-1:0]   window_q, window_d;
  logic                pend_v_q, pend_v_d;
  res_t                pend_q, pend_d;
  logic [TIME_W-1:0]   sum_q, sum_d;
  logic                m_valid_q, m_valid_d;
  res_t                m_res_q, m_res_d;
  logic                m_last_q, m_last_d;

  // Slot table
  logic [TIME_W-1:0]   mem_dl  [SLOTS];
  logic [PER_W-1:0]    mem_per [SLOTS];
  logic [VAL_W-1:0]    mem_val [SLOTS];
  logic [TIME_W-1:0]   rd_dl_q;
  logic [PER_W-1:0]    rd_per_q;
  logic [VAL_W-1:0]    rd_val_q;
  logic                mem_we;
  logic                mem_we_start;
  logic [SLOT_W-1:0]   mem_addr;
  logic [TIME_W-1:0]   mem_dl_wdata;

  // Datapath helpers
  logic                in_accept;
  logic                out_free;
  logic                gate_live;
  logic                slot_ok;
  logic                idx_last;
  logic [TIME_W-1:0]   due_diff;
  logic [TIME_W-1:0]   lag;
  logic [TIME_W-1:0]   resync_dl;
  logic [TIME_W-1:0]   new_dl;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign gate_live = gate_open_q && diff_pos(gate_dl_q - time_q);
  assign slot_ok   = 32'(in_slot) < SLOTS;
  assign idx_last  = (idx_q == SLOT_W'(SLOTS - 1));

  // Due test and deadline step with resync
  assign due_diff  = time_q - rd_dl_q;
  assign lag       = time_q - sum_q;
  assign resync_dl = time_q + TIME_W'(rd_per_q);
  assign new_dl    = (!lag[TIME_W-1] && (lag > TIME_W'(rd_per_q))) ? resync_dl : sum_q;

  // Sequencer next-state logic
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    time_d       = time_q;
    gate_open_d  = gate_open_q;
    gate_dl_d    = gate_dl_q;
    en_d         = en_q;
    window_d     = window_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    sum_d        = sum_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_res_d      = m_res_q;
    m_last_d     = m_last_q;
    mem_we       = 1'b0;
    mem_we_start = 1'b0;
    mem_addr     = idx_q;
    mem_dl_wdata = new_dl;

    if (cfg_valid_i) begin
      window_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        mem_addr     = in_slot[SLOT_W-1:0];
        mem_dl_wdata = time_q;
        if (in_accept) begin
          case (in_func)
            FUNC_TICK: begin
              time_d  = time_q + 1'b1;
              state_d = S_GATE;
            end
            FUNC_ARM: begin
              gate_open_d = 1'b1;
              gate_dl_d   = time_q + window_q;
            end
            FUNC_DISARM: begin
              gate_open_d = 1'b0;
              en_d        = '0;
            end
            FUNC_START: begin
              if (slot_ok && (in_period != '0)) begin
                if (gate_live) begin
                  mem_we       = 1'b1;
                  mem_we_start = 1'b1;
                  en_d[in_slot[SLOT_W-1:0]] = 1'b1;
                end else begin
                  pend_v_d = 1'b1;
                  pend_d   = '{ev: EV_REFUSED, slot: in_slot, value: in_value};
                  state_d  = S_FLUSH;
                end
              end
            end
            FUNC_STOP: begin
              if (slot_ok) begin
                en_d[in_slot[SLOT_W-1:0]] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      // Gate expiry check against the advanced time
      S_GATE: begin
        idx_d = '0;
        if (gate_open_q && !gate_live) begin
          gate_open_d = 1'b0;
          en_d        = '0;
          pend_v_d    = 1'b1;
          pend_d      = '{ev: EV_EXPIRED, slot: 4'd0, value: '0};
          state_d     = S_FLUSH;
        end else begin
          state_d = S_SCAN;
        end
      end

      // Skip disabled slots; table read of idx is registered meanwhile
      S_SCAN: begin
        if (en_q[idx_q]) begin
          state_d = S_DUE;
        end else if (idx_last) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DUE: begin
        if (due_diff[TIME_W-1]) begin
          if (idx_last) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN;
          end
        end else begin
          sum_d   = rd_dl_q + TIME_W'(rd_per_q);
          state_d = S_FIRE;
        end
      end

      // Write back the deadline and queue the fire event
      S_FIRE: begin
        if (!pend_v_q || out_free) begin
          mem_we = 1'b1;
          if (pend_v_q) begin
            m_valid_d = 1'b1;
            m_res_d   = pend_q;
            m_last_d  = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = '{ev: EV_FIRE, slot: 4'(idx_q), value: rd_val_q};
          if (idx_last) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end

      // Send the held result as the final one of this request
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_res_d   = pend_q;
          m_last_d  = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      time_q      <= '0;
      gate_open_q <= 1'b0;
      gate_dl_q   <= '0;
      en_q        <= '0;
      window_q    <= ARM_WINDOW_RST;
      pend_v_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      m_last_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      time_q      <= time_d;
      gate_open_q <= gate_open_d;
      gate_dl_q   <= gate_dl_d;
      en_q        <= en_d;
      window_q    <= window_d;
      pend_v_q    <= pend_v_d;
      m_valid_q   <= m_valid_d;
      m_last_q    <= m_last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    sum_q   <= sum_d;
    m_res_q <= m_res_d;
  end

  // Slot table: one write port, registered read at the walk index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_dl[mem_addr] <= mem_dl_wdata;
    end
    if (mem_we_start) begin
      mem_per[mem_addr] <= in_period;
      mem_val[mem_addr] <= in_value;
    end
    rd_dl_q  <= mem_dl[idx_q];
    rd_per_q <= mem_per[idx_q];
    rd_val_q <= mem_val[idx_q];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_res_q.value, m_res_q.slot, m_res_q.ev};
  assign m_axis_tlast_o  = m_last_q;

  // Checks
  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("held result left over in idle");

  a_en_needs_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_q != '0) |-> gate_open_q)
    else $error("slot enabled while gate closed");

  a_close_stops_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(gate_open_q) |-> (en_q == '0))
    else $error("gate closed without stopping slots");

  a_fire_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRE && pend_v_q && !out_free) |=> (state_q == S_FIRE))
    else $error("slot walk advanced over a stalled result");

endmodule

[bench/armed_periodic_send_scheduler_tb.sv]
// Self-checking bench for armed_periodic_send_scheduler: queue-fed stream driver,
// result monitor and a cycle-free scheduler predictor. Depends on asps_pkg and the RTL.
`timescale 1ns / 1ps

module armed_periodic_send_scheduler_tb;
  import asps_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 48;

  // One request item, func field in the low bits
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] period;
    logic [3:0]  slot;
    logic [2:0]  func;
  } req_t;

  // One result item
  typedef struct packed {
    logic [1:0]  ev;
    logic [3:0]  slot;
    logic [31:0] value;
    logic        last;
  } sched_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  armed_periodic_send_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Shadow scheduler state
  logic [31:0] sc_window = ARM_WINDOW_RST;
  logic        sc_gate_open = 1'b0;
  logic [31:0] sc_gate_deadline = '0;
  logic [31:0] sc_now = '0;
  logic [15:0] sc_enabled = '0;
  logic [31:0] sc_value    [SLOTS];
  logic [31:0] sc_deadline [SLOTS];
  logic [15:0] sc_period   [SLOTS];

  req_t         req_backlog[$];
  sched_event_t awaited_events[$];
  req_t         cur_req = '0;
  bit           src_busy = 1'b0;
  int           src_wait = 0;
  int           snk_wait = 0;
  int           src_wait_max = 0;
  int           snk_wait_max = 0;
  int           n_errors = 0;
  int           n_cycles = 0;
  sched_event_t seen_ev;
  sched_event_t want_ev;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Gate is live while open and its deadline is still ahead of now
  function automatic bit gate_live();
    logic [31:0] d;
    d = sc_gate_deadline - sc_now;
    return sc_gate_open && (d != '0) && !d[31];
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void apply_request(req_t r);
    sched_event_t evs[$];
    sched_event_t e;
    logic [31:0]  d;
    logic [31:0]  p;
    int           i;
    case (r.func)
      FUNC_TICK: begin
        sc_now = sc_now + 32'd1;
        if (sc_gate_open && !gate_live()) begin
          sc_gate_open = 1'b0;
          sc_enabled   = '0;
          e = '{ev: EV_EXPIRED, slot: 4'd0, value: 32'd0, last: 1'b0};
          evs.push_back(e);
        end
        // walk due slots in ascending order
        for (i = 0; i < SLOTS; i++) begin
          d = sc_now - sc_deadline[i];
          if (sc_enabled[i] && !d[31]) begin
            p = 32'(sc_period[i]);
            sc_deadline[i] = sc_deadline[i] + p;
            d = sc_now - sc_deadline[i];
            if (!d[31] && d > p) sc_deadline[i] = sc_now + p;
            e = '{ev: EV_FIRE, slot: 4'(i), value: sc_value[i], last: 1'b0};
            evs.push_back(e);
          end
        end
      end
      FUNC_ARM: begin
        sc_gate_open     = 1'b1;
        sc_gate_deadline = sc_now + sc_window;
      end
      FUNC_DISARM: begin
        sc_gate_open = 1'b0;
        sc_enabled   = '0;
      end
      FUNC_START: begin
        if (r.period != '0) begin
          if (!gate_live()) begin
            e = '{ev: EV_REFUSED, slot: r.slot, value: r.value, last: 1'b0};
            evs.push_back(e);
          end else begin
            sc_value[r.slot]    = r.value;
            sc_period[r.slot]   = r.period;
            sc_deadline[r.slot] = sc_now;
            sc_enabled[r.slot]  = 1'b1;
          end
        end
      end
      FUNC_STOP: begin
        sc_enabled[r.slot] = 1'b0;
      end
      default: ;
    endcase
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) awaited_events.push_back(evs[k]);
  endfunction

  // Request driver: one item per handshake, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_busy = 1'b0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_request(cur_req);
        src_busy = 1'b0;
        src_wait = $urandom_range(0, src_wait_max);
      end
      if (!src_busy) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (req_backlog.size() > 0) begin
          cur_req  = req_backlog.pop_front();
          src_busy = 1'b1;
        end
      end
      s_axis_tvalid_i <= src_busy;
      s_axis_tdata_i  <= {1'b0, cur_req};
    end
  end

  // Result monitor: stalls at random, checks against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      snk_wait = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen_ev = '{ev: m_axis_tdata_o[1:0], slot: m_axis_tdata_o[5:2],
                    value: m_axis_tdata_o[37:6], last: m_axis_tlast_o};
        if (awaited_events.size() == 0) begin
          $error("unexpected result: event_res %0d slot_res %0d send_value_res %h",
                 seen_ev.ev, seen_ev.slot, seen_ev.value);
          n_errors++;
        end else begin
          want_ev = awaited_events.pop_front();
          if (seen_ev.ev !== want_ev.ev) begin
            $error("event_res: expected %0d, got %0d", want_ev.ev, seen_ev.ev);
            n_errors++;
          end
          if (seen_ev.slot !== want_ev.slot) begin
            $error("slot_res: expected %0d, got %0d", want_ev.slot, seen_ev.slot);
            n_errors++;
          end
          if (seen_ev.value !== want_ev.value) begin
            $error("send_value_res: expected %h, got %h", want_ev.value, seen_ev.value);
            n_errors++;
          end
          if (seen_ev.last !== want_ev.last) begin
            $error("last: expected %0d, got %0d", want_ev.last, seen_ev.last);
            n_errors++;
          end
        end
        snk_wait = $urandom_range(0, snk_wait_max);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_req(input logic [2:0] func, input logic [3:0] slot,
                          input logic [15:0] period, input logic [31:0] value);
    req_t r;
    r = '{value: value, period: period, slot: slot, func: func};
    req_backlog.push_back(r);
  endtask

  // Wait until every item is in, every result is out, and the block is idle
  task automatic settle();
    while (req_backlog.size() != 0 || src_busy || awaited_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] w);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sc_window = w;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly short periods so slots fire often; sometimes zero or full range
  function automatic logic [15:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 16'($urandom_range(1, 6));
    if (roll < 85) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Arm / start / tick sessions with some stops and disarms and random content, plus some noise
  task automatic gen_random(input int n_items);
    int made;
    int roll;
    int k;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        push_req(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 16'($urandom_range(0, 65535)), $urandom);
        made++;
      end else begin
        if (roll >= 20) begin
          push_req(FUNC_ARM, 4'($urandom_range(0, 15)), 16'($urandom), $urandom);
          made++;
        end
        repeat ($urandom_range(1, 5)) begin
          push_req(FUNC_START, 4'($urandom_range(0, 15)), pick_period(), $urandom);
          made++;
        end
        k = $urandom_range(1, 10);
        repeat (k) begin
          if ($urandom_range(0, 9) == 0)
            push_req(FUNC_STOP, 4'($urandom_range(0, 15)), 16'($urandom), $urandom);
          else if ($urandom_range(0, 9) == 0)
            push_req(FUNC_START, 4'($urandom_range(0, 15)), pick_period(), $urandom);
          else
            push_req(FUNC_TICK, 4'($urandom_range(0, 15)), 16'($urandom), $urandom);
          made++;
        end
        if ($urandom_range(0, 4) == 0) begin
          push_req(FUNC_DISARM, 4'($urandom_range(0, 15)), 16'($urandom), $urandom);
          made++;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] windows[7];
    int          ph;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: gate closed, zero period, fires, stop, unused codes, disarm
    push_req(FUNC_START, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(FUNC_START, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_ARM, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_START, 4'd0, 16'd1, 32'd0);
    push_req(FUNC_START, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(FUNC_START, 4'd7, 16'd2, 32'hA5A5_5A5A);
    push_req(FUNC_START, 4'd3, 16'd0, 32'h1234_5678);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_STOP, 4'd7, 16'd0, 32'd0);
    push_req(FUNC_STOP, 4'd9, 16'd0, 32'd0);
    push_req(3'd5, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    push_req(3'd6, 4'd1, 16'd1, 32'd1);
    push_req(3'd7, 4'd2, 16'd2, 32'd2);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_DISARM, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_START, 4'd4, 16'd3, 32'hDEAD_BEEF);
    settle();

    // Shortest window: the gate expires on the next tick
    write_window(32'd1);
    push_req(FUNC_ARM, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_START, 4'd2, 16'd1, 32'h0F0F_0F0F);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    push_req(FUNC_STOP, 4'd2, 16'd0, 32'd0);
    push_req(FUNC_TICK, 4'd0, 16'd0, 32'd0);
    settle();

    // Random phases over extreme and small windows
    windows[0] = 32'hFFFF_FFFF;
    windows[1] = 32'h8000_0000;
    windows[2] = 32'h7FFF_FFFF;
    windows[3] = 32'($urandom_range(2, 40));
    windows[4] = 32'd60000;
    windows[5] = 32'($urandom_range(5, 15));
    windows[6] = 32'd1;
    for (ph = 0; ph < 7; ph++) begin
      write_window(windows[ph]);
      src_wait_max = (ph % 3 == 1) ? 0 : 4;
      snk_wait_max = (ph % 3 == 2) ? 0 : 4;
      gen_random(PHASE_ITEMS);
      settle();
    end

    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
